[rtl/core/lpfe_pkg.sv]
package lpfe_pkg;

    // Number formats
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int EXP_BITS  = 30;
    localparam int DL_W      = WORD_BITS + 1;

    // Configuration port
    localparam int CFG_W = 32;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_COEF_A      = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_B      = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_C      = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_D      = 3'd3;
    localparam logic [IDX_W-1:0] REG_REST_LENGTH = 3'd4;

    // Q30 constants of the exponential
    localparam logic [EXP_BITS:0]   EXP_ONE   = 31'h4000_0000;
    localparam logic [30:0]         LOG2E_Q30 = 31'd1549082005;
    localparam logic [EXP_BITS-1:0] LN2_Q30   = 30'd744261118;

    // Clamp limits
    localparam logic [20:0] T_LIM    = 21'h10_0000;
    localparam logic [48:0] NUM_LIM  = 49'h4000_0000_0000;
    localparam logic [62:0] TERM_CAP = 63'h100_0000_0000;
    localparam logic [WORD_BITS-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [WORD_BITS-1:0] WORD_MIN = 32'h8000_0000;

    // Divider chain lengths (quotient bits)
    localparam int BC_N = 48;
    localparam int T_N  = 21;
    localparam int S_N  = 31;
    localparam int H_N  = 47;
    localparam int HORNER_STEPS = 7;

    // Side data carried through the divider and series chains
    typedef struct packed {
        logic [DL_W-1:0] dl;
        logic            ovf;
        logic            neg;
    } tpay_t;

    typedef struct packed {
        logic [DL_W-1:0] dl;
        logic [4:0]      n;
        logic            neg_t;
    } epay_t;

    typedef struct packed {
        logic [47:0] fmag;
        logic [31:0] t1;
        logic        neg_dl;
    } hpay_t;

    // Exact reciprocal multiplier for v / k, v below 2^31
    function automatic logic [31:0] recip_mult(input int k);
        logic [31:0] m;
        case (k) inside
            3, 6:    m = 32'd2863311531;
            5:       m = 32'd3435973837;
            7:       m = 32'd2454267027;
            default: m = 32'h8000_0000;
        endcase
        return m;
    endfunction

    function automatic int recip_shift(input int k);
        int s;
        case (k) inside
            1:       s = 31;
            2:       s = 32;
            3, 4:    s = 33;
            default: s = 34;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/lpfe_ifs.sv]
interface lpfe_in_if;
    import lpfe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

interface lpfe_out_if;
    import lpfe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] force_res;
    logic [WORD_BITS-1:0] stiffness;
    logic                 saturated;

    modport source (output valid, output force_res, output stiffness, output saturated,
                    input ready);
    modport sink   (input valid, input force_res, input stiffness, input saturated,
                    output ready);
endinterface

[rtl/core/lpfe_div_cell.sv]
module lpfe_div_cell #(
    parameter int N     = 8,
    parameter int DW    = 31,
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DW-1:0]    in_rem,
    input  logic [N-1:0]     in_bits,
    input  logic [DW-1:0]    in_dvs,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [DW-1:0]    out_rem,
    output logic [N-1:0]     out_bits,
    output logic [DW-1:0]    out_dvs,
    output logic [PAY_W-1:0] out_pay
);
    logic [DW:0]    trial;
    logic           take;
    logic [DW-1:0]  rem_next;
    logic [N-1:0]   bits_next;
    logic           valid_reg;
    logic [DW-1:0]  rem_reg;
    logic [N-1:0]   bits_reg;
    logic [DW-1:0]  dvs_reg;
    logic [PAY_W-1:0] pay_reg;

    // One restoring step: bring down a dividend bit, subtract if it fits
    assign trial     = {in_rem, in_bits[N-1]};
    assign take      = (trial >= {1'b0, in_dvs});
    assign rem_next  = take ? DW'(trial - {1'b0, in_dvs}) : trial[DW-1:0];
    assign bits_next = {in_bits[N-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
            dvs_reg  <= in_dvs;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_bits  = bits_reg;
    assign out_dvs   = dvs_reg;
    assign out_pay   = pay_reg;

endmodule

[rtl/core/lpfe_div_chain.sv]
module lpfe_div_chain #(
    parameter int N     = 8,
    parameter int DW    = 31,
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DW-1:0]    in_rem,
    input  logic [N-1:0]     in_bits,
    input  logic [DW-1:0]    in_dvs,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [N-1:0]     out_quo,
    output logic [PAY_W-1:0] out_pay
);
    logic             v    [N+1];
    logic [DW-1:0]    rem  [N+1];
    logic [N-1:0]     bits [N+1];
    logic [DW-1:0]    dvs  [N+1];
    logic [PAY_W-1:0] pay  [N+1];

    assign v[0]    = in_valid;
    assign rem[0]  = in_rem;
    assign bits[0] = in_bits;
    assign dvs[0]  = in_dvs;
    assign pay[0]  = in_pay;

    // One quotient bit per cell, MSB first
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        lpfe_div_cell #(
            .N     (N),
            .DW    (DW),
            .PAY_W (PAY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[i]),
            .in_rem    (rem[i]),
            .in_bits   (bits[i]),
            .in_dvs    (dvs[i]),
            .in_pay    (pay[i]),
            .out_valid (v[i+1]),
            .out_rem   (rem[i+1]),
            .out_bits  (bits[i+1]),
            .out_dvs   (dvs[i+1]),
            .out_pay   (pay[i+1])
        );
    end

    assign out_valid = v[N];
    assign out_quo   = bits[N];
    assign out_pay   = pay[N];

endmodule

[rtl/core/lpfe_exp_cell.sv]
module lpfe_exp_cell #(
    parameter int K     = 1,
    parameter int PAY_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [lpfe_pkg::EXP_BITS-1:0] in_r,
    input  logic [lpfe_pkg::EXP_BITS:0]   in_p,
    input  logic [PAY_W-1:0]            in_pay,
    output logic                        out_valid,
    output logic [lpfe_pkg::EXP_BITS-1:0] out_r,
    output logic [lpfe_pkg::EXP_BITS:0]   out_p,
    output logic [PAY_W-1:0]            out_pay
);
    import lpfe_pkg::*;

    localparam logic [31:0] MUL = recip_mult(K);
    localparam int          SH  = recip_shift(K);

    logic [60:0]          rp_full;
    logic [EXP_BITS-1:0]  prod_next;
    logic [61:0]          qprod;
    logic [EXP_BITS-1:0]  quo;
    logic [EXP_BITS:0]    p_next;
    logic                 v1_reg;
    logic [EXP_BITS-1:0]  prod_reg;
    logic [EXP_BITS-1:0]  r1_reg;
    logic [PAY_W-1:0]     pay1_reg;
    logic                 v2_reg;
    logic [EXP_BITS-1:0]  r2_reg;
    logic [EXP_BITS:0]    p2_reg;
    logic [PAY_W-1:0]     pay2_reg;

    // First half: r * p in Q30
    assign rp_full   = 61'(in_r) * 61'(in_p);
    assign prod_next = rp_full[59:30];

    // Second half: divide by K through its reciprocal, p = 1 - r*p/K
    assign qprod  = 62'(prod_reg) * 62'(MUL);
    assign quo    = EXP_BITS'(qprod >> SH);
    assign p_next = EXP_ONE - {1'b0, quo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            r1_reg   <= in_r;
            pay1_reg <= in_pay;
            p2_reg   <= p_next;
            r2_reg   <= r1_reg;
            pay2_reg <= pay1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_r     = r2_reg;
    assign out_p     = p2_reg;
    assign out_pay   = pay2_reg;

endmodule

[rtl/core/logistic_pair_force_eval.sv]
// Channel   Dir  Beat fields                            Handshake
// sample    in   distance                               valid/ready
// result    out  force_res, stiffness, saturated        valid/ready
// cfg       in   cfg_idx, cfg_data                      cfg_we, no back-pressure
//
// One beat in per cycle while the pipeline advances, one result per beat, in order.
// The pipeline is four restoring divider chains (48, 21, 31 and 47 cells,
// one quotient bit per cell), seven two-stage series cells and twelve glue stages.
// The whole pipeline advances only when the output register is empty or taken;
// sample.ready follows that enable.
// Reset clears valid bits; the coefficient registers come up as A=B=L=0, C=D=1.0.
module logistic_pair_force_eval (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lpfe_pkg::IDX_W-1:0] cfg_idx,
    input  logic [lpfe_pkg::CFG_W-1:0] cfg_data,
    lpfe_in_if.sink                    sample,
    lpfe_out_if.source                 result
);
    import lpfe_pkg::*;

    // Coefficient registers
    logic [31:0] coef_a_reg;
    logic [31:0] coef_b_reg;
    logic [30:0] coef_c_reg;
    logic [30:0] coef_d_reg;
    logic [31:0] rest_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg   <= '0;
            coef_b_reg   <= '0;
            coef_c_reg   <= 31'h1_0000;
            coef_d_reg   <= 31'h1_0000;
            rest_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_COEF_A:      coef_a_reg   <= cfg_data;
                REG_COEF_B:      coef_b_reg   <= cfg_data;
                REG_COEF_C:      coef_c_reg   <= cfg_data[30:0];
                REG_COEF_D:      coef_d_reg   <= cfg_data[30:0];
                REG_REST_LENGTH: rest_len_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Values derived from the coefficients (user must keep stable while items in flight; not enforced)
    logic        neg_a;
    logic        neg_b;
    logic [31:0] aa;
    logic [31:0] ab;
    logic [30:0] c_eff;
    logic [30:0] d_eff;

    assign neg_a = coef_a_reg[31];
    assign neg_b = coef_b_reg[31];
    assign aa    = neg_a ? (32'd0 - coef_a_reg) : coef_a_reg;
    assign ab    = neg_b ? (32'd0 - coef_b_reg) : coef_b_reg;
    assign c_eff = (coef_c_reg == '0) ? 31'd1 : coef_c_reg;
    assign d_eff = (coef_d_reg == '0) ? 31'd1 : coef_d_reg;

    // Global advance
    logic en;
    logic out_v_reg;

    assign en           = !out_v_reg || result.ready;
    assign sample.ready = en;

    // S0: dl = x - L
    logic            s0_v_reg;
    logic [DL_W-1:0] s0_dl_next;
    logic [DL_W-1:0] s0_dl_reg;

    assign s0_dl_next = {sample.distance[31], sample.distance}
                      - {rest_len_reg[31], rest_len_reg};

    // Offset B/C
    logic            a_v;
    logic [BC_N-1:0] bc_mag;
    logic [DL_W-1:0] a_dl;

    lpfe_div_chain #(.N(BC_N), .DW(31), .PAY_W(DL_W)) u_bc_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_v_reg),
        .in_rem    (31'd0),
        .in_bits   ({ab, 16'd0}),
        .in_dvs    (c_eff),
        .in_pay    (s0_dl_reg),
        .out_valid (a_v),
        .out_quo   (bc_mag),
        .out_pay   (a_dl)
    );

    // S1: num = dl - bc
    logic            s1_v_reg;
    logic [48:0]     bc_s;
    logic [48:0]     s1_num_next;
    logic [48:0]     s1_num_reg;
    logic [DL_W-1:0] s1_dl_reg;

    assign bc_s        = neg_b ? (49'd0 - {1'b0, bc_mag}) : {1'b0, bc_mag};
    assign s1_num_next = {{16{a_dl[32]}}, a_dl} - bc_s;

    // S2: clamp |num|, check quotient range ahead of the t divider
    logic            s2_v_reg;
    logic [48:0]     num_abs;
    logic [46:0]     s2_mag_next;
    logic            s2_ovf_next;
    logic [46:0]     s2_mag_reg;
    logic            s2_ovf_reg;
    logic            s2_neg_reg;
    logic [DL_W-1:0] s2_dl_reg;
    tpay_t           t_pay_in;

    assign num_abs     = s1_num_reg[48] ? (49'd0 - s1_num_reg) : s1_num_reg;
    assign s2_mag_next = (num_abs > NUM_LIM) ? NUM_LIM[46:0] : num_abs[46:0];
    assign s2_ovf_next = (s2_mag_next >= {11'd0, d_eff, 5'd0});
    assign t_pay_in    = '{dl: s2_dl_reg, ovf: s2_ovf_reg, neg: s2_neg_reg};

    logic           b_v;
    logic [T_N-1:0] t_quo;
    tpay_t          b_pay;

    lpfe_div_chain #(.N(T_N), .DW(31), .PAY_W($bits(tpay_t))) u_t_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_v_reg),
        .in_rem    (s2_ovf_reg ? 31'd0 : s2_mag_reg[35:5]),
        .in_bits   ({s2_mag_reg[4:0], 16'd0}),
        .in_dvs    (d_eff),
        .in_pay    (t_pay_in),
        .out_valid (b_v),
        .out_quo   (t_quo),
        .out_pay   (b_pay)
    );

    // S3: clamp |t|
    logic            s3_v_reg;
    logic [20:0]     s3_tmag_next;
    logic [20:0]     s3_tmag_reg;
    logic            s3_neg_reg;
    logic [DL_W-1:0] s3_dl_reg;

    assign s3_tmag_next = (b_pay.ovf || (t_quo > T_LIM)) ? T_LIM : t_quo;

    // S4: y = |t| * log2(e), split into integer n and fraction f
    logic            s4_v_reg;
    logic [35:0]     y_hi;
    logic [46:0]     y_lo;
    logic [35:0]     y_sum;
    logic [4:0]      s4_n_reg;
    logic [29:0]     s4_f_reg;
    logic            s4_neg_reg;
    logic [DL_W-1:0] s4_dl_reg;

    assign y_hi  = 36'(s3_tmag_reg[20:16]) * 36'(LOG2E_Q30);
    assign y_lo  = 47'(s3_tmag_reg[15:0]) * 47'(LOG2E_Q30);
    assign y_sum = y_hi + 36'(y_lo >> FRAC_BITS);

    // S5: r = f * ln2
    logic            s5_v_reg;
    logic [59:0]     r_full;
    logic [29:0]     s5_r_reg;
    epay_t           s5_pay_reg;

    assign r_full = 60'(s4_f_reg) * 60'(LN2_Q30);

    // Horner series for exp(-r)
    logic                h_v   [HORNER_STEPS+1];
    logic [EXP_BITS-1:0] h_r   [HORNER_STEPS+1];
    logic [EXP_BITS:0]   h_p   [HORNER_STEPS+1];
    epay_t               h_pay [HORNER_STEPS+1];

    assign h_v[0]   = s5_v_reg;
    assign h_r[0]   = s5_r_reg;
    assign h_p[0]   = EXP_ONE;
    assign h_pay[0] = s5_pay_reg;

    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_horner
        lpfe_exp_cell #(.K(HORNER_STEPS - i), .PAY_W($bits(epay_t))) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (h_v[i]),
            .in_r      (h_r[i]),
            .in_p      (h_p[i]),
            .in_pay    (h_pay[i]),
            .out_valid (h_v[i+1]),
            .out_r     (h_r[i+1]),
            .out_p     (h_p[i+1]),
            .out_pay   (h_pay[i+1])
        );
    end

    // S6: u = p >> n, set up s = u/(1+u) or 1/(1+u)
    logic            s6_v_reg;
    logic [30:0]     u_w;
    logic [31:0]     s6_dvs_next;
    logic [31:0]     s6_rem_next;
    logic [30:0]     s6_bits_next;
    logic [31:0]     s6_dvs_reg;
    logic [31:0]     s6_rem_reg;
    logic [30:0]     s6_bits_reg;
    logic [DL_W-1:0] s6_dl_reg;

    assign u_w          = h_p[HORNER_STEPS] >> h_pay[HORNER_STEPS].n;
    assign s6_dvs_next  = {1'b0, EXP_ONE} + {1'b0, u_w};
    assign s6_rem_next  = h_pay[HORNER_STEPS].neg_t ? 32'h2000_0000 : {2'd0, u_w[30:1]};
    assign s6_bits_next = h_pay[HORNER_STEPS].neg_t ? 31'd0 : {u_w[0], 30'd0};

    logic            c_v;
    logic [S_N-1:0]  s_quo;
    logic [DL_W-1:0] c_dl;

    lpfe_div_chain #(.N(S_N), .DW(32), .PAY_W(DL_W)) u_s_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_v_reg),
        .in_rem    (s6_rem_reg),
        .in_bits   (s6_bits_reg),
        .in_dvs    (s6_dvs_reg),
        .in_pay    (s6_dl_reg),
        .out_valid (c_v),
        .out_quo   (s_quo),
        .out_pay   (c_dl)
    );

    // S7: q = s(1-s), w = |dl| s, t1 = |A| s
    logic        s7_v_reg;
    logic [31:0] adl;
    logic [61:0] q_full;
    logic [62:0] w_full;
    logic [62:0] t1_full;
    logic [28:0] s7_q_reg;
    logic [31:0] s7_w_reg;
    logic [31:0] s7_t1_reg;
    logic [31:0] s7_adl_reg;
    logic        s7_negdl_reg;

    assign adl     = c_dl[32] ? 32'(33'd0 - c_dl) : c_dl[31:0];
    assign q_full  = 62'(s_quo) * 62'(EXP_ONE - s_quo);
    assign w_full  = 63'(adl) * 63'(s_quo);
    assign t1_full = 63'(aa) * 63'(s_quo);

    // S8: |force| = (|A| w) >> F, g = |dl| q
    logic        s8_v_reg;
    logic [63:0] f_full;
    logic [60:0] g_full;
    logic [47:0] s8_fmag_reg;
    logic [30:0] s8_g_reg;
    logic [31:0] s8_t1_reg;
    logic        s8_negdl_reg;
    hpay_t       h_pay_in;

    assign f_full   = 64'(aa) * 64'(s7_w_reg);
    assign g_full   = 61'(s7_adl_reg) * 61'(s7_q_reg);
    assign h_pay_in = '{fmag: s8_fmag_reg, t1: s8_t1_reg, neg_dl: s8_negdl_reg};

    logic           d_v;
    logic [H_N-1:0] h_quo;
    hpay_t          d_pay;

    lpfe_div_chain #(.N(H_N), .DW(31), .PAY_W($bits(hpay_t))) u_h_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s8_v_reg),
        .in_rem    (31'd0),
        .in_bits   ({s8_g_reg, 16'd0}),
        .in_dvs    (d_eff),
        .in_pay    (h_pay_in),
        .out_valid (d_v),
        .out_quo   (h_quo),
        .out_pay   (d_pay)
    );

    // S9: |A| h as two partial products
    logic        s9_v_reg;
    logic [55:0] s9_plo_reg;
    logic [54:0] s9_phi_reg;
    hpay_t       s9_pay_reg;

    // S10: second term capped, force saturated
    logic        s10_v_reg;
    logic [78:0] ah_full;
    logic [62:0] ah_sh;
    logic [40:0] s10_t2_next;
    logic        neg_f9;
    logic        f_over;
    logic [31:0] s10_force_next;
    logic [40:0] s10_t2_reg;
    logic [31:0] s10_force_reg;
    logic        s10_fsat_reg;
    logic [31:0] s10_t1_reg;
    logic        s10_negf_reg;

    assign ah_full     = {s9_phi_reg, 24'd0} + 79'(s9_plo_reg);
    assign ah_sh       = 63'(ah_full >> FRAC_BITS);
    assign s10_t2_next = (ah_sh > TERM_CAP) ? TERM_CAP[40:0] : ah_sh[40:0];
    assign neg_f9      = neg_a ^ s9_pay_reg.neg_dl;
    assign f_over      = neg_f9 ? (s9_pay_reg.fmag > 48'h8000_0000)
                                : (s9_pay_reg.fmag > 48'h7fff_ffff);
    assign s10_force_next = f_over ? (neg_f9 ? WORD_MIN : WORD_MAX)
                          : (neg_f9 ? (32'd0 - s9_pay_reg.fmag[31:0])
                                    : s9_pay_reg.fmag[31:0]);

    // S11: stiffness = t1 - t2, saturate, output register
    logic [42:0] t1s;
    logic [42:0] t2s;
    logic [42:0] stiff_w;
    logic        st_over;
    logic [31:0] out_stiff_next;
    logic [31:0] out_force_reg;
    logic [31:0] out_stiff_reg;
    logic        out_sat_reg;

    assign t1s     = neg_a ? (43'd0 - 43'(s10_t1_reg)) : 43'(s10_t1_reg);
    assign t2s     = s10_negf_reg ? (43'd0 - 43'(s10_t2_reg)) : 43'(s10_t2_reg);
    assign stiff_w = t1s - t2s;
    assign st_over = (stiff_w[42:31] != {12{stiff_w[42]}});
    assign out_stiff_next = st_over ? (stiff_w[42] ? WORD_MIN : WORD_MAX) : stiff_w[31:0];

    // Valid bits of the glue stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg  <= sample.valid;
            s1_v_reg  <= a_v;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= b_v;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= h_v[HORNER_STEPS];
            s7_v_reg  <= c_v;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= d_v;
            s10_v_reg <= s9_v_reg;
            out_v_reg <= s10_v_reg;
        end
    end

    // Payload of the glue stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_dl_reg      <= s0_dl_next;
            s1_num_reg     <= s1_num_next;
            s1_dl_reg      <= a_dl;
            s2_mag_reg     <= s2_mag_next;
            s2_ovf_reg     <= s2_ovf_next;
            s2_neg_reg     <= s1_num_reg[48];
            s2_dl_reg      <= s1_dl_reg;
            s3_tmag_reg    <= s3_tmag_next;
            s3_neg_reg     <= b_pay.neg && (s3_tmag_next != '0);
            s3_dl_reg      <= b_pay.dl;
            s4_n_reg       <= y_sum[34:30];
            s4_f_reg       <= y_sum[29:0];
            s4_neg_reg     <= s3_neg_reg;
            s4_dl_reg      <= s3_dl_reg;
            s5_r_reg       <= r_full[59:30];
            s5_pay_reg     <= '{dl: s4_dl_reg, n: s4_n_reg, neg_t: s4_neg_reg};
            s6_dvs_reg     <= s6_dvs_next;
            s6_rem_reg     <= s6_rem_next;
            s6_bits_reg    <= s6_bits_next;
            s6_dl_reg      <= h_pay[HORNER_STEPS].dl;
            s7_q_reg       <= q_full[58:30];
            s7_w_reg       <= w_full[61:30];
            s7_t1_reg      <= t1_full[61:30];
            s7_adl_reg     <= adl;
            s7_negdl_reg   <= c_dl[32];
            s8_fmag_reg    <= f_full[63:16];
            s8_g_reg       <= g_full[60:30];
            s8_t1_reg      <= s7_t1_reg;
            s8_negdl_reg   <= s7_negdl_reg;
            s9_plo_reg     <= 56'(aa) * 56'(h_quo[23:0]);
            s9_phi_reg     <= 55'(aa) * 55'(h_quo[46:24]);
            s9_pay_reg     <= d_pay;
            s10_t2_reg     <= s10_t2_next;
            s10_force_reg  <= s10_force_next;
            s10_fsat_reg   <= f_over;
            s10_t1_reg     <= s9_pay_reg.t1;
            s10_negf_reg   <= neg_f9;
            out_force_reg  <= s10_force_reg;
            out_stiff_reg  <= out_stiff_next;
            out_sat_reg    <= s10_fsat_reg || st_over;
        end
    end

    assign result.valid     = out_v_reg;
    assign result.force_res = out_force_reg;
    assign result.stiffness = out_stiff_reg;
    assign result.saturated = out_sat_reg;

    // A raised flag always comes with a value pinned at a bound
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_sat_reg) |->
            (out_force_reg == WORD_MAX || out_force_reg == WORD_MIN ||
             out_stiff_reg == WORD_MAX || out_stiff_reg == WORD_MIN))
        else $error("saturated flag without a clamped result");

    // |t| never passes the exponent clamp
    a_t_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> (s3_tmag_reg <= T_LIM))
        else $error("exponent argument above clamp");

    // Logistic factor stays within [0, 1]
    a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_v |-> (s_quo <= EXP_ONE))
        else $error("logistic factor above one");

    // Series result never exceeds one
    a_p_range: assert property (@(posedge clk) disable iff (!rst_n)
        h_v[HORNER_STEPS] |-> (h_p[HORNER_STEPS] <= EXP_ONE))
        else $error("series value above one");

endmodule

[tb/sv/logistic_pair_force_eval_tb.sv]
module logistic_pair_force_eval_tb;
    import lpfe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 260;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int N_RANDOM     = 1950;

    typedef struct packed {
        logic [WORD_BITS-1:0] force_res;
        logic [WORD_BITS-1:0] stiffness;
        logic                 saturated;
    } force_beat_t;

    typedef struct {
        logic [WORD_BITS-1:0] distance;
        bit                   typed;
        force_beat_t          want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    lpfe_in_if  sample ();
    lpfe_out_if result ();

    logistic_pair_force_eval dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .sample   (sample.sink),
        .result   (result.source)
    );

    // shadow of the coefficient registers
    logic signed [31:0] amp;
    logic signed [31:0] offs_num;
    logic        [30:0] offs_den;
    logic        [30:0] width_d;
    logic signed [31:0] rest_len;

    force_beat_t pending_forces[$];
    int          errors;
    int          beats_sent;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic logic [WORD_BITS-1:0] clamp_word(longint v, inout bit hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return WORD_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return WORD_MIN;
        end
        return v[WORD_BITS-1:0];
    endfunction

    // bit-exact prediction of one result beat
    function automatic force_beat_t logistic_force(logic [WORD_BITS-1:0] x);
        longint          a, b, c, d, dl, bc, num, t, force_v, t1s, t2s;
        longint          one_f, num_lim, t_lim;
        longint unsigned ta, y, n, r, p, u, s, q, adl, aa, w, g, h, t1, t2, one_q;
        bit              neg_a, neg_dl, hit;
        force_beat_t     res;
        one_q   = longint'(EXP_ONE);
        one_f   = 64'sd1 << FRAC_BITS;
        num_lim = 64'sd1 << (62 - FRAC_BITS);
        t_lim   = 64'sd16 * one_f;
        a  = amp;
        b  = offs_num;
        c  = (offs_den == 0) ? 1 : longint'(offs_den);
        d  = (width_d == 0) ? 1 : longint'(width_d);
        dl = longint'(signed'(x)) - longint'(rest_len);
        bc = (b * one_f) / c;
        num = dl - bc;
        if (num > num_lim) num = num_lim;
        if (num < -num_lim) num = -num_lim;
        t = (num * one_f) / d;
        if (t > t_lim) t = t_lim;
        if (t < -t_lim) t = -t_lim;
        // exp(-|t|) by range reduction and a Horner series
        ta = magnitude(t);
        y  = (ta >> FRAC_BITS) * LOG2E_Q30
           + (((ta & ((64'd1 << FRAC_BITS) - 1)) * LOG2E_Q30) >> FRAC_BITS);
        n  = y >> EXP_BITS;
        r  = ((y & (one_q - 1)) * LN2_Q30) >> EXP_BITS;
        p  = one_q;
        for (int k = HORNER_STEPS; k >= 1; k--)
            p = one_q - ((r * p) >> EXP_BITS) / longint'(k);
        u = (n >= 63) ? 0 : (p >> n);
        if (t >= 0)
            s = (u << EXP_BITS) / (one_q + u);
        else
            s = (one_q << EXP_BITS) / (one_q + u);
        q = (s * (one_q - s)) >> EXP_BITS;
        adl    = magnitude(dl);
        aa     = magnitude(a);
        neg_a  = a < 0;
        neg_dl = dl < 0;
        w = (adl * s) >> EXP_BITS;
        force_v = longint'((aa * w) >> FRAC_BITS);
        if (neg_a != neg_dl) force_v = -force_v;
        t1  = (aa * s) >> EXP_BITS;
        t1s = neg_a ? -longint'(t1) : longint'(t1);
        g = (adl * q) >> EXP_BITS;
        h = (g << FRAC_BITS) / longint'(d);
        if (aa != 0 && h > (64'h8000_0000_0000_0000 / aa))
            t2 = TERM_CAP;
        else
            t2 = (aa * h) >> FRAC_BITS;
        if (t2 > TERM_CAP) t2 = TERM_CAP;
        t2s = (neg_a != neg_dl) ? -longint'(t2) : longint'(t2);
        hit = 1'b0;
        res.force_res = clamp_word(force_v, hit);
        res.stiffness = clamp_word(t1s - t2s, hit);
        res.saturated = hit;
        return res;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we   = 1'b0;
        case (idx)
            REG_COEF_A:      amp      = val;
            REG_COEF_B:      offs_num = val;
            REG_COEF_C:      offs_den = val[30:0];
            REG_COEF_D:      width_d  = val[30:0];
            REG_REST_LENGTH: rest_len = val;
            default: ;
        endcase
    endtask

    // wait out the pipeline before touching registers
    task automatic drain();
        while (pending_forces.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d, logic [31:0] l);
        drain();
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
        write_reg(REG_COEF_D, d);
        write_reg(REG_REST_LENGTH, l);
    endtask

    function automatic void set_idling();
        if (beats_sent < N_RANDOM / 3)
        begin
            send_idle_pct = 36;
            recv_idle_pct = 50;
        end
        else if (beats_sent < 2 * N_RANDOM / 3)
        begin
            send_idle_pct = 50;
            recv_idle_pct = 36;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    // drive one beat from the falling edge; valid stays high into the next beat
    task automatic send_distance(logic [WORD_BITS-1:0] x, bit typed, force_beat_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample.valid = 1'b0;
            @(negedge clk);
        end
        sample.valid    = 1'b1;
        sample.distance = x;
        do
            @(posedge clk);
        while (!sample.ready);
        pending_forces.push_back(typed ? want : logistic_force(x));
        beats_sent++;
        set_idling();
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_distance();
        longint span;
        if ($urandom_range(3) == 0)
            return $urandom;
        // near the logistic knee so both factors carry weight
        span = (width_d == 0) ? 64'sd1 : longint'(width_d);
        span = span * longint'($urandom_range(40)) / 4;
        return 32'(longint'(rest_len) + longint'(offs_num) * 65536 /
                   ((offs_den == 0) ? 1 : longint'(offs_den))
                   + (($urandom_range(1) != 0) ? span : -span)
                   + longint'(signed'(16'($urandom))));
    endfunction

    // receiver back-pressure
    always @(negedge clk)
        result.ready = ($urandom_range(99) >= recv_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_forces.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                force_beat_t want;
                want = pending_forces.pop_front();
                if (result.force_res !== want.force_res)
                begin
                    $error("force_res: expected %h, got %h", want.force_res, result.force_res);
                    errors++;
                end
                if (result.stiffness !== want.stiffness)
                begin
                    $error("stiffness: expected %h, got %h", want.stiffness, result.stiffness);
                    errors++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated: expected %b, got %b", want.saturated, result.saturated);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("logistic_pair_force_eval_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   rows[$];
        force_beat_t zero_beat;
        force_beat_t none;
        int          per_phase;
        zero_beat       = '0;
        none            = '0;
        errors          = 0;
        beats_sent      = 0;
        cycles          = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        sample.valid    = 1'b0;
        sample.distance = '0;
        result.ready    = 1'b0;
        amp      = 0;
        offs_num = 0;
        offs_den = 31'd65536;
        width_d  = 31'd65536;
        rest_len = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset A is zero, so every result is zero
        rows.push_back('{32'h8000_0000, 1'b1, zero_beat});
        rows.push_back('{32'h7fff_ffff, 1'b1, zero_beat});
        rows.push_back('{32'h0000_0000, 1'b1, zero_beat});
        rows.push_back('{32'hffff_ffff, 1'b1, zero_beat});
        rows.push_back('{32'h0001_0000, 1'b1, zero_beat});
        rows.push_back('{32'h5555_aaaa, 1'b1, zero_beat});
        foreach (rows[i])
            send_distance(rows[i].distance, rows[i].typed, rows[i].want);
        sample.valid = 1'b0;

        // extremes: huge A, zero divisors, tiny and huge widths, clamped exponent
        rows.delete();
        rows.push_back('{32'h8000_0000, 1'b0, none});
        rows.push_back('{32'h7fff_ffff, 1'b0, none});
        rows.push_back('{32'h0000_0000, 1'b0, none});
        rows.push_back('{32'hffff_ffff, 1'b0, none});
        rows.push_back('{32'h0000_8000, 1'b0, none});
        rows.push_back('{32'hfff0_0000, 1'b0, none});
        set_coefs(32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h0);
        foreach (rows[i])
            send_distance(rows[i].distance, rows[i].typed, rows[i].want);
        sample.valid = 1'b0;
        set_coefs(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff);
        foreach (rows[i])
            send_distance(rows[i].distance, rows[i].typed, rows[i].want);
        sample.valid = 1'b0;
        set_coefs(32'h0003_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000, 32'h8000_0000);
        foreach (rows[i])
            send_distance(rows[i].distance, rows[i].typed, rows[i].want);
        sample.valid = 1'b0;

        // random phases with fresh coefficients
        beats_sent = 0;
        set_idling();
        per_phase = N_RANDOM / 13;
        for (int ph = 0; ph < 13; ph++)
        begin
            logic [31:0] cd;
            sample.valid = 1'b0;
            cd = (ph % 4 == 0) ? $urandom : $urandom_range(32'h0010_0000, 32'h0000_0400);
            set_coefs((ph % 3 == 0) ? $urandom : 32'(signed'(20'($urandom))),
                      (ph % 2 == 0) ? $urandom : 32'(signed'(18'($urandom))),
                      (ph % 5 == 1) ? $urandom : $urandom_range(32'h0004_0000, 32'h0000_4000),
                      cd,
                      (ph % 4 == 3) ? $urandom : 32'(signed'(22'($urandom))));
            for (int i = 0; i < per_phase; i++)
            begin
                if (ph == 6 && i == per_phase / 2)
                begin
                    // hold off until the pipeline is empty
                    sample.valid = 1'b0;
                    while (pending_forces.size() != 0)
                        @(negedge clk);
                end
                send_distance(rand_distance(), 1'b0, none);
            end
        end
        sample.valid = 1'b0;

        drain();
        if (errors == 0)
            $display("logistic_pair_force_eval_tb: PASS");
        else
            $display("logistic_pair_force_eval_tb: FAIL");
        $finish;
    end

endmodule
